FILE: design/midi_chord_segmenter_macros.svh
// Assertion macros shared by the chord segmenter RTL.
// Needs clk and arst_n in scope where a macro is used.
`ifndef MIDI_CHORD_SEGMENTER_MACROS_SVH
`define MIDI_CHORD_SEGMENTER_MACROS_SVH

// same-cycle implication, off while in reset
`define MCS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MCS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mcs_pkg.sv
// Types, codes and constants of the MIDI chord segmenter.
// No dependencies; used by every module of the block.
`default_nettype none

package mcs_pkg;

	localparam int MAX_HELD    = 64;
	localparam int NOTE_W      = 7;
	localparam int NOTES       = 128;
	localparam int CNT_W       = 7;
	localparam int TIME_W      = 16;
	localparam int CHUNK_W     = 16;
	localparam int NCHUNK      = NOTES / CHUNK_W;
	localparam int CHUNK_IDX_W = $clog2(NCHUNK);
	localparam int BIT_IDX_W   = $clog2(CHUNK_W);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [1:0] MODE_NOTE  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	localparam logic [1:0] KIND_CHANGE = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;

	localparam logic [1:0] SEG_END     = 2'd0;
	localparam logic [1:0] SEG_START   = 2'd1;
	localparam logic [1:0] SEG_ONGOING = 2'd2;
	localparam logic [1:0] SEG_EXTEND  = 2'd3;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_EXTEND = 1'b1;

	localparam logic [TIME_W-1:0] WINDOW_RST = 16'd60;
	localparam logic [TIME_W-1:0] EXTEND_RST = 16'd30;

	typedef struct packed {
		logic [1:0]        mode;
		logic [NOTE_W-1:0] note;
		logic [NOTE_W-1:0] velocity;
	} in_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        seg_state;
		logic [NOTE_W-1:0] held_note;
		logic              chord_empty;
		logic              flushed;
		logic              last;
	} out_t;

	// one listing job: header plus a snapshot of the held-note bitmap
	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       seg_state;
		logic             flushed;
		logic [CNT_W-1:0] cnt;
		logic [NOTES-1:0] notes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// lowest set bit of a chunk
	function automatic logic [BIT_IDX_W-1:0] ffs_chunk(input logic [CHUNK_W-1:0] v);
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = i[BIT_IDX_W-1:0];
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: design/mcs_front.sv
// Front end: takes items, keeps the held-note bitmap, count and window timer,
// and pushes listing jobs. Depends on mcs_pkg.
`default_nettype none

module mcs_front
	import mcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire in_t               item,
	input  wire logic [TIME_W-1:0] window_ticks,
	input  wire logic [TIME_W-1:0] extension_ticks,
	output logic                   push,
	output job_t                   job
);

	logic [NOTES-1:0]  held_q, held_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [TIME_W-1:0] win_q, win_d;
	logic              is_held;
	logic              room;
	logic              changed;
	logic [1:0]        seg;

	assign is_held = held_q[item.note];
	assign room    = count_q < CNT_W'(MAX_HELD);

	always_comb begin
		held_d      = held_q;
		count_d     = count_q;
		win_d       = win_q;
		changed     = 1'b0;
		seg         = SEG_END;
		push        = 1'b0;
		job.kind    = KIND_CHANGE;
		job.flushed = 1'b0;
		if (accept) begin
			case (item.mode)
				MODE_NOTE: begin
					if (item.velocity != '0) begin
						if (!is_held && room) begin
							held_d[item.note] = 1'b1;
							count_d           = count_q + CNT_W'(1);
							changed           = 1'b1;
						end
					end else if (is_held) begin
						held_d[item.note] = 1'b0;
						count_d           = count_q - CNT_W'(1);
						changed           = 1'b1;
					end
					if (changed) begin
						push = 1'b1;
						if (win_q != '0) begin
							if (win_q < extension_ticks) begin
								win_d = extension_ticks;
								seg   = SEG_EXTEND;
							end else begin
								seg = SEG_ONGOING;
							end
						end else begin
							win_d = window_ticks;
							seg   = SEG_START;
						end
					end
				end
				MODE_TICK: begin
					if (win_q != '0) begin
						win_d = win_q - TIME_W'(1);
						if (win_q == TIME_W'(1)) begin
							push     = 1'b1;
							job.kind = KIND_END;
						end
					end
				end
				MODE_FLUSH: begin
					held_d      = '0;
					count_d     = '0;
					win_d       = '0;
					push        = 1'b1;
					job.kind    = KIND_FLUSH;
					job.flushed = (count_q != '0);
				end
				default: begin
				end
			endcase
		end
		job.seg_state = seg;
		job.cnt       = count_d;
		job.notes     = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
			win_q   <= '0;
		end else begin
			held_q  <= held_d;
			count_q <= count_d;
			win_q   <= win_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/mcs_queue.sv
// Short job queue between front end and lister.
// Depends on mcs_pkg.
`default_nettype none

module mcs_queue
	import mcs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wdata,
	input  wire logic pop,
	output job_t      rdata,
	output q_stat_t   stat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/mcs_back.sv
// Back end: pops jobs and lists held notes in ascending order, one word
// per hit, scanning the bitmap snapshot a 16-note chunk at a time. Depends on mcs_pkg.
`default_nettype none

module mcs_back
	import mcs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t stat,
	input  wire job_t    job,
	output logic         pop,
	output logic         valid,
	output out_t         result
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_SCAN = 2'b10
	} back_state_t;

	back_state_t            state_q;
	logic [NOTES-1:0]       scan_q;
	logic [CNT_W-1:0]       rem_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [1:0]             kind_q;
	logic [1:0]             seg_q;
	logic                   valid_q;
	out_t                   res_q;

	logic [NOTE_W-1:0]    base;
	logic [CHUNK_W-1:0]   chunk;
	logic                 hit;
	logic [BIT_IDX_W-1:0] bit_idx;
	logic [NOTE_W-1:0]    note_idx;

	assign base     = {chunk_q, {BIT_IDX_W{1'b0}}};
	assign chunk    = scan_q[base +: CHUNK_W];
	assign hit      = |chunk;
	assign bit_idx  = ffs_chunk(chunk);
	assign note_idx = {chunk_q, bit_idx};
	assign pop      = (state_q == B_IDLE) && !stat.empty;
	assign valid    = valid_q;
	assign result   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (job.kind == KIND_FLUSH || job.cnt == '0) begin
							// single word: flush report or empty chord
							valid_q           <= 1'b1;
							res_q.kind        <= job.kind;
							res_q.seg_state   <= job.seg_state;
							res_q.held_note   <= '0;
							res_q.chord_empty <= 1'b1;
							res_q.flushed     <= job.flushed;
							res_q.last        <= 1'b1;
						end else begin
							scan_q  <= job.notes;
							rem_q   <= job.cnt;
							chunk_q <= '0;
							kind_q  <= job.kind;
							seg_q   <= job.seg_state;
							state_q <= B_SCAN;
						end
					end
				end
				B_SCAN: begin
					if (hit) begin
						valid_q           <= 1'b1;
						res_q.kind        <= kind_q;
						res_q.seg_state   <= seg_q;
						res_q.held_note   <= note_idx;
						res_q.chord_empty <= 1'b0;
						res_q.flushed     <= 1'b0;
						res_q.last        <= (rem_q == CNT_W'(1));
						scan_q[note_idx]  <= 1'b0;
						rem_q             <= rem_q - CNT_W'(1);
						if (rem_q == CNT_W'(1)) begin
							state_q <= B_IDLE;
						end
					end else begin
						chunk_q <= chunk_q + CHUNK_IDX_W'(1);
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/midi_chord_segmenter.sv
// Channel   | handshake                      | payload
// ----------+--------------------------------+-----------------------------
// config    | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
// item in   | start && !busy                 | item   (in_t)
// result    | valid, one cycle, no stall     | result (out_t)
//
// An item is taken while start is high and busy is low; the front end updates the
// note set and window timer at once and, if the set changes, the window ends or a
// flush comes, queues a listing job (2 entries). The lister pops a job when idle,
// then lists up to 64 notes, one word per hit, stepping past empty 16-note chunks.
// busy is high only while the job queue is full. Reset clears the note set,
// the window and the queue; config registers return to 60 and 30 ticks.
// Top level of the chord segmenter; depends on mcs_pkg, mcs_front, mcs_queue,
// mcs_back and the assertion macro header.
`default_nettype none
`include "midi_chord_segmenter_macros.svh"

module midi_chord_segmenter
	import mcs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	input  wire logic              start,
	input  wire in_t               item,
	output logic                   busy,
	output logic                   valid,
	output out_t                   result
);

	logic [TIME_W-1:0] window_q;
	logic [TIME_W-1:0] extend_q;
	logic              cfg_wr;
	logic              reg_sel;
	logic              in_acc;
	logic              push;
	logic              pop;
	job_t              job_in;
	job_t              job_out;
	q_stat_t           q_stat;

	// registers sit at 4-byte steps; the low address bits do not decode
	assign reg_sel = paddr[APB_AW-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_comb begin
		case (reg_sel)
			REG_WINDOW: prdata = {{(APB_DW-TIME_W){1'b0}}, window_q};
			REG_EXTEND: prdata = {{(APB_DW-TIME_W){1'b0}}, extend_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			extend_q <= EXTEND_RST;
		end else if (cfg_wr) begin
			if (reg_sel == REG_WINDOW) begin
				window_q <= pwdata[TIME_W-1:0];
			end else begin
				extend_q <= pwdata[TIME_W-1:0];
			end
		end
	end

	assign busy   = q_stat.full;
	assign in_acc = start && !busy;

	mcs_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (in_acc),
		.item            (item),
		.window_ticks    (window_q),
		.extension_ticks (extend_q),
		.push            (push),
		.job             (job_in)
	);

	mcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.pop    (pop),
		.rdata  (job_out),
		.stat   (q_stat)
	);

	mcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (q_stat),
		.job    (job_out),
		.pop    (pop),
		.valid  (valid),
		.result (result)
	);

	`MCS_ASSERT_IMP(a_flush_single, valid && result.kind == KIND_FLUSH,
		result.last && result.chord_empty, "flush report must be a single empty word")
	`MCS_ASSERT_IMP(a_empty_is_last, valid && result.chord_empty, result.last,
		"empty chord word must close its list")
	`MCS_ASSERT_IMP(a_flushed_only_flush, valid && result.kind != KIND_FLUSH,
		!result.flushed && (result.kind != KIND_END || result.seg_state == SEG_END),
		"bad report header")
	`MCS_ASSERT_NXT(a_job_queued, in_acc && push, !q_stat.empty,
		"accepted job missing from queue")

endmodule

`default_nettype wire
